### rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// expects i_clk and i_rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication with the consequent in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/pmsm_pkg.sv
// types and widths for the pooled mean and deviation pipeline
// no dependencies
package pmsm_pkg;

    localparam int CNT_W  = 24;
    localparam int N_W    = CNT_W + 1;
    localparam int MEAN_W = 32;
    localparam int SD_W   = 31;
    localparam int MAG_W  = CNT_W + MEAN_W + 1;
    localparam int NN_W   = 2 * N_W;
    localparam int VQ_W   = 64;
    localparam int RT_W   = VQ_W / 2;
    localparam int X_W    = 113;

    localparam logic [SD_W-1:0] SD_MAX = {SD_W{1'b1}};

    typedef struct packed {
        logic        [CNT_W-1:0]  count_a;
        logic signed [MEAN_W-1:0] mean_a;
        logic        [SD_W-1:0]   stdev_a;
        logic        [CNT_W-1:0]  count_b;
        logic signed [MEAN_W-1:0] mean_b;
        logic        [SD_W-1:0]   stdev_b;
    } t_in_item;

    typedef struct packed {
        logic        [N_W-1:0]    pooled_count;
        logic signed [MEAN_W-1:0] pooled_mean;
        logic        [SD_W-1:0]   pooled_stdev;
        logic                     empty_flag;
    } t_out_item;

    // travels beside the variance division
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
        logic [N_W-1:0]   n;
        logic             ovf;
        logic             empty;
    } t_sb_var;

    // travels beside the mean division
    typedef struct packed {
        logic [VQ_W-1:0] varq;
        logic            neg;
        logic [N_W-1:0]  n;
        logic            ovf;
        logic            empty;
    } t_sb_mean;

    // travels beside the square root
    typedef struct packed {
        logic [MEAN_W-1:0] mean;
        logic [N_W-1:0]    n;
        logic              ovf;
        logic              empty;
    } t_sb_sqrt;

endpackage

### rtl/pooled_mean_stdev_merge_core.sv
// pooled count, mean and deviation of two sample groups, one per unstalled cycle
// depends on pmsm_pkg, pmsm_div, pmsm_sqrt and assert_macros.svh
//
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_ready    i_in_data  (pmsm_pkg::t_in_item)
// out       source     o_out_valid / i_out_ready  o_out_data (pmsm_pkg::t_out_item)
//
// one transaction accepted per cycle unless stalled; nine arithmetic stages,
// a 64 stage variance divider, a 32 stage mean divider, a 32 stage square root
// and the output register
// synchronous active-low reset clears the valid bits only
// when the output register holds an untaken result the whole pipeline stalls
`include "assert_macros.svh"

module pooled_mean_stdev_merge_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  pmsm_pkg::t_in_item   i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output pmsm_pkg::t_out_item  o_out_data
);

    localparam int SB1_W = $bits(pmsm_pkg::t_sb_var);
    localparam int SB2_W = $bits(pmsm_pkg::t_sb_mean);
    localparam int SB3_W = $bits(pmsm_pkg::t_sb_sqrt);

    logic w_en;
    logic r_out_v;
    pmsm_pkg::t_out_item r_out;

    assign w_en = !r_out_v || i_out_ready;

    // stage 1: magnitudes and mean difference
    logic        r1_v, r2_v, r3_v, r4_v, r5_v, r6_v, r7_v, r8_v, r9_v;
    logic [23:0] r1_na, r1_nb;
    logic [24:0] r1_n;
    logic [31:0] r1_ama, r1_amb, r1_diff;
    logic        r1_nega, r1_negb;
    logic [30:0] r1_sa, r1_sb;
    logic [32:0] w_dm, w_dneg;
    logic [31:0] w_ama, w_amb;

    assign w_ama  = i_in_data.mean_a[31] ? (~i_in_data.mean_a + 32'd1) : i_in_data.mean_a;
    assign w_amb  = i_in_data.mean_b[31] ? (~i_in_data.mean_b + 32'd1) : i_in_data.mean_b;
    assign w_dm   = {i_in_data.mean_a[31], i_in_data.mean_a}
                  - {i_in_data.mean_b[31], i_in_data.mean_b};
    assign w_dneg = ~w_dm + 33'd1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_na   <= i_in_data.count_a;
            r1_nb   <= i_in_data.count_b;
            r1_n    <= {1'b0, i_in_data.count_a} + {1'b0, i_in_data.count_b};
            r1_ama  <= w_ama;
            r1_amb  <= w_amb;
            r1_nega <= i_in_data.mean_a[31];
            r1_negb <= i_in_data.mean_b[31];
            r1_diff <= w_dm[32] ? w_dneg[31:0] : w_dm[31:0];
            r1_sa   <= i_in_data.stdev_a;
            r1_sb   <= i_in_data.stdev_b;
        end
    end

    // stage 2: first products
    logic [55:0] r2_pa, r2_pb;
    logic [61:0] r2_sa2, r2_sb2;
    logic [63:0] r2_d2;
    logic [47:0] r2_nab;
    logic [49:0] r2_nn;
    logic [23:0] r2_na, r2_nb;
    logic [24:0] r2_n;
    logic        r2_nega, r2_negb;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pa   <= r1_na * r1_ama;
            r2_pb   <= r1_nb * r1_amb;
            r2_sa2  <= r1_sa * r1_sa;
            r2_sb2  <= r1_sb * r1_sb;
            r2_d2   <= r1_diff * r1_diff;
            r2_nab  <= r1_na * r1_nb;
            r2_nn   <= r1_n * r1_n;
            r2_na   <= r1_na;
            r2_nb   <= r1_nb;
            r2_n    <= r1_n;
            r2_nega <= r1_nega;
            r2_negb <= r1_negb;
        end
    end

    // stage 3: signed mean sum, partial products of the variance terms
    logic [57:0] r3_mv;
    logic [54:0] r3_wa_lo, r3_wa_hi, r3_wb_lo, r3_wb_hi;
    logic [55:0] r3_p00, r3_p01, r3_p10, r3_p11;
    logic [24:0] r3_n;
    logic [49:0] r3_nn;
    logic [57:0] w_va, w_vb;

    assign w_va = r2_nega ? (58'd0 - {2'b00, r2_pa}) : {2'b00, r2_pa};
    assign w_vb = r2_negb ? (58'd0 - {2'b00, r2_pb}) : {2'b00, r2_pb};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_mv    <= w_va + w_vb;
            r3_wa_lo <= r2_na * r2_sa2[30:0];
            r3_wa_hi <= r2_na * r2_sa2[61:31];
            r3_wb_lo <= r2_nb * r2_sb2[30:0];
            r3_wb_hi <= r2_nb * r2_sb2[61:31];
            r3_p00   <= r2_nab[23:0] * r2_d2[31:0];
            r3_p01   <= r2_nab[23:0] * r2_d2[63:32];
            r3_p10   <= r2_nab[47:24] * r2_d2[31:0];
            r3_p11   <= r2_nab[47:24] * r2_d2[63:32];
            r3_n     <= r2_n;
            r3_nn    <= r2_nn;
        end
    end

    // stage 4: mean sign and magnitude, first partial sums
    logic        r4_neg;
    logic [56:0] r4_mag;
    logic [85:0] r4_wa, r4_wb;
    logic [87:0] r4_pl, r4_ph;
    logic [24:0] r4_n;
    logic [49:0] r4_nn;
    logic [57:0] w_mneg;

    assign w_mneg = 58'd0 - r3_mv;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_neg <= r3_mv[57];
            r4_mag <= r3_mv[57] ? w_mneg[56:0] : r3_mv[56:0];
            r4_wa  <= {31'd0, r3_wa_lo} + {r3_wa_hi, 31'd0};
            r4_wb  <= {31'd0, r3_wb_lo} + {r3_wb_hi, 31'd0};
            r4_pl  <= {32'd0, r3_p00} + {r3_p01, 32'd0};
            r4_ph  <= {32'd0, r3_p10} + {r3_p11, 32'd0};
            r4_n   <= r3_n;
            r4_nn  <= r3_nn;
        end
    end

    // stage 5: within-group sum and between-group product
    logic         r5_neg;
    logic [56:0]  r5_mag;
    logic [86:0]  r5_w;
    logic [111:0] r5_p;
    logic [24:0]  r5_n;
    logic [49:0]  r5_nn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_neg <= r4_neg;
            r5_mag <= r4_mag;
            r5_w   <= {1'b0, r4_wa} + {1'b0, r4_wb};
            r5_p   <= {24'd0, r4_pl} + {r4_ph, 24'd0};
            r5_n   <= r4_n;
            r5_nn  <= r4_nn;
        end
    end

    // stage 6: within-group sum times total count, in three slices
    logic         r6_neg;
    logic [56:0]  r6_mag;
    logic [53:0]  r6_m0, r6_m1, r6_m2;
    logic [111:0] r6_p;
    logic [24:0]  r6_n;
    logic [49:0]  r6_nn;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_neg <= r5_neg;
            r6_mag <= r5_mag;
            r6_m0  <= r5_w[28:0] * r5_n;
            r6_m1  <= r5_w[57:29] * r5_n;
            r6_m2  <= r5_w[86:58] * r5_n;
            r6_p   <= r5_p;
            r6_n   <= r5_n;
            r6_nn  <= r5_nn;
        end
    end

    // stages 7 and 8: numerator over the squared count
    logic         r7_neg, r8_neg, r9_neg;
    logic [56:0]  r7_mag, r8_mag, r9_mag;
    logic [82:0]  r7_a;
    logic [112:0] r7_b;
    logic [112:0] r8_x, r9_x;
    logic [24:0]  r7_n, r8_n, r9_n;
    logic [49:0]  r7_nn, r8_nn, r9_nn;
    logic         r9_ovf;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_neg <= r6_neg;
            r7_mag <= r6_mag;
            r7_a   <= {29'd0, r6_m0} + {r6_m1, 29'd0};
            r7_b   <= {1'b0, r6_p} + {1'b0, r6_m2, 58'd0};
            r7_n   <= r6_n;
            r7_nn  <= r6_nn;
            r8_neg <= r7_neg;
            r8_mag <= r7_mag;
            r8_x   <= {30'd0, r7_a} + r7_b;
            r8_n   <= r7_n;
            r8_nn  <= r7_nn;
            // stage 9: a quotient that needs more than 64 bits saturates
            r9_neg <= r8_neg;
            r9_mag <= r8_mag;
            r9_x   <= r8_x;
            r9_n   <= r8_n;
            r9_nn  <= r8_nn;
            r9_ovf <= ({1'b0, r8_x[112:64]} >= r8_nn);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_in_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
            r8_v <= r7_v;
            r9_v <= r8_v;
        end
    end

    // variance division by the squared count
    pmsm_pkg::t_sb_var  w_sb1_in, w_sb1_out;
    logic [SB1_W-1:0]   w_sb1_vec;
    logic [49:0]        w_vrem;
    logic               w_d1_v;
    logic [63:0]        w_varq;

    assign w_sb1_in = '{neg: r9_neg, mag: r9_mag, n: r9_n, ovf: r9_ovf,
                        empty: (r9_n == '0)};
    assign w_vrem   = r9_ovf ? 50'd0 : {1'b0, r9_x[112:64]};

    pmsm_div #(.QW(64), .DW(50), .SBW(SB1_W)) u_div_var (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r9_v),
        .i_rem   (w_vrem),
        .i_low   (r9_x[63:0]),
        .i_div   (r9_nn),
        .i_sb    (w_sb1_in),
        .o_valid (w_d1_v),
        .o_quot  (w_varq),
        .o_sb    (w_sb1_vec)
    );

    assign w_sb1_out = w_sb1_vec;

    // mean division by the total count
    pmsm_pkg::t_sb_mean w_sb2_in, w_sb2_out;
    logic [SB2_W-1:0]   w_sb2_vec;
    logic               w_d2_v;
    logic [31:0]        w_mq;

    assign w_sb2_in = '{varq: w_varq, neg: w_sb1_out.neg, n: w_sb1_out.n,
                        ovf: w_sb1_out.ovf, empty: w_sb1_out.empty};

    pmsm_div #(.QW(32), .DW(25), .SBW(SB2_W)) u_div_mean (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d1_v),
        .i_rem   (w_sb1_out.mag[56:32]),
        .i_low   (w_sb1_out.mag[31:0]),
        .i_div   (w_sb1_out.n),
        .i_sb    (w_sb2_in),
        .o_valid (w_d2_v),
        .o_quot  (w_mq),
        .o_sb    (w_sb2_vec)
    );

    assign w_sb2_out = w_sb2_vec;

    // square root of the variance
    pmsm_pkg::t_sb_sqrt w_sb3_in, w_sb3_out;
    logic [SB3_W-1:0]   w_sb3_vec;
    logic               w_sq_v;
    logic [31:0]        w_root;

    assign w_sb3_in = '{mean: (w_sb2_out.neg ? (32'd0 - w_mq) : w_mq), n: w_sb2_out.n,
                        ovf: w_sb2_out.ovf, empty: w_sb2_out.empty};

    pmsm_sqrt #(.RW(pmsm_pkg::RT_W), .SBW(SB3_W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_d2_v),
        .i_x     (w_sb2_out.varq),
        .i_sb    (w_sb3_in),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_sb    (w_sb3_vec)
    );

    assign w_sb3_out = w_sb3_vec;

    // output register
    pmsm_pkg::t_out_item n_out;

    always_comb begin
        n_out.pooled_count = w_sb3_out.n;
        n_out.empty_flag   = w_sb3_out.empty;
        if (w_sb3_out.empty) begin
            n_out.pooled_mean  = '0;
            n_out.pooled_stdev = '0;
        end else begin
            n_out.pooled_mean = w_sb3_out.mean;
            if (w_sb3_out.ovf || w_root[31]) begin
                n_out.pooled_stdev = pmsm_pkg::SD_MAX;
            end else begin
                n_out.pooled_stdev = w_root[30:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_out_v <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out <= n_out;
        end
    end

    assign o_in_ready  = w_en;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    `ASSERT_IMPL(a_empty_zero, o_out_valid && o_out_data.empty_flag,
        (o_out_data.pooled_mean == '0) && (o_out_data.pooled_stdev == '0),
        "empty transaction with nonzero mean or deviation")
    `ASSERT_IMPL(a_empty_count, o_out_valid,
        o_out_data.empty_flag == (o_out_data.pooled_count == '0),
        "empty flag disagrees with pooled count")
    `ASSERT_NEXT(a_stall_holds, o_out_valid && !i_out_ready && r9_v, r9_v,
        "pipeline stage advanced during an output stall")

endmodule

### rtl/pmsm_div.sv
// pipelined restoring divider, one quotient bit per stage, with sideband
// depends on assert_macros.svh
`include "assert_macros.svh"

module pmsm_div #(
    parameter int QW  = 32,
    parameter int DW  = 25,
    parameter int SBW = 8
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  logic [DW-1:0]  i_rem,
    input  logic [QW-1:0]  i_low,
    input  logic [DW-1:0]  i_div,
    input  logic [SBW-1:0] i_sb,
    output logic           o_valid,
    output logic [QW-1:0]  o_quot,
    output logic [SBW-1:0] o_sb
);

    logic           r_v   [QW];
    logic [DW-1:0]  r_rem [QW];
    logic [QW-1:0]  r_lq  [QW];
    logic [DW-1:0]  r_d   [QW];
    logic [SBW-1:0] r_sb  [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           w_v;
        logic [DW-1:0]  w_rem;
        logic [QW-1:0]  w_lq;
        logic [DW-1:0]  w_d;
        logic [SBW-1:0] w_sb;
        logic [DW:0]    w_t;
        logic [DW:0]    w_sub;
        logic           w_ge;
        logic [DW-1:0]  n_rem;
        logic [QW-1:0]  n_lq;

        if (k == 0) begin : g_first
            assign w_v   = i_valid;
            assign w_rem = i_rem;
            assign w_lq  = i_low;
            assign w_d   = i_div;
            assign w_sb  = i_sb;
        end else begin : g_next
            assign w_v   = r_v[k-1];
            assign w_rem = r_rem[k-1];
            assign w_lq  = r_lq[k-1];
            assign w_d   = r_d[k-1];
            assign w_sb  = r_sb[k-1];
        end

        // low bits shift out at the top while quotient bits enter at the bottom
        assign w_t   = {w_rem, w_lq[QW-1]};
        assign w_sub = w_t - {1'b0, w_d};
        assign w_ge  = (w_t >= {1'b0, w_d});
        assign n_rem = w_ge ? w_sub[DW-1:0] : w_t[DW-1:0];
        assign n_lq  = {w_lq[QW-2:0], w_ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_lq[k]  <= n_lq;
                r_d[k]   <= w_d;
                r_sb[k]  <= w_sb;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_lq[QW-1];
    assign o_sb    = r_sb[QW-1];

    for (genvar k = 0; k < QW; k++) begin : g_chk
        `ASSERT_IMPL(a_rem_below_div, r_v[k] && (r_d[k] != '0), r_rem[k] < r_d[k],
            "partial remainder not below divisor")
    end

endmodule

### rtl/pmsm_sqrt.sv
// pipelined integer square root, two radicand bits per stage, with sideband
// depends on assert_macros.svh
`include "assert_macros.svh"

module pmsm_sqrt #(
    parameter int RW  = 32,
    parameter int SBW = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [2*RW-1:0] i_x,
    input  logic [SBW-1:0]  i_sb,
    output logic            o_valid,
    output logic [RW-1:0]   o_root,
    output logic [SBW-1:0]  o_sb
);

    logic            r_v    [RW];
    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_x    [RW];
    logic [SBW-1:0]  r_sb   [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic            w_v;
        logic [RW+1:0]   w_rem;
        logic [RW-1:0]   w_root;
        logic [2*RW-1:0] w_x;
        logic [SBW-1:0]  w_sb;
        logic [RW+3:0]   w_t;
        logic [RW+3:0]   w_trial;
        logic [RW+3:0]   w_sub;
        logic            w_ge;
        logic [RW+1:0]   n_rem;
        logic [RW-1:0]   n_root;
        logic [2*RW-1:0] n_x;

        if (k == 0) begin : g_first
            assign w_v    = i_valid;
            assign w_rem  = '0;
            assign w_root = '0;
            assign w_x    = i_x;
            assign w_sb   = i_sb;
        end else begin : g_next
            assign w_v    = r_v[k-1];
            assign w_rem  = r_rem[k-1];
            assign w_root = r_root[k-1];
            assign w_x    = r_x[k-1];
            assign w_sb   = r_sb[k-1];
        end

        assign w_t     = {w_rem, w_x[2*RW-1 -: 2]};
        assign w_trial = {2'b00, w_root, 2'b01};
        assign w_sub   = w_t - w_trial;
        assign w_ge    = (w_t >= w_trial);
        assign n_rem   = w_ge ? w_sub[RW+1:0] : w_t[RW+1:0];
        assign n_root  = {w_root[RW-2:0], w_ge};
        assign n_x     = {w_x[2*RW-3:0], 2'b00};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= w_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_x[k]    <= n_x;
                r_sb[k]   <= w_sb;
            end
        end
    end

    assign o_valid = r_v[RW-1];
    assign o_root  = r_root[RW-1];
    assign o_sb    = r_sb[RW-1];

    for (genvar k = 0; k < RW; k++) begin : g_chk
        `ASSERT_IMPL(a_rem_bounded, r_v[k], r_rem[k] <= {1'b0, r_root[k], 1'b0},
            "root remainder above twice the root")
    end

endmodule
